// ===== design/toeq_pkg.sv =====
// Shared types and constants for the time-ordered event queue.
`timescale 1ns / 1ps
`default_nettype none

package toeq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = IDX_W + 1;

   // Field widths
   localparam int TIME_W   = 64;
   localparam int BYTE_W   = 8;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 7;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TAKE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

   localparam logic [TIME_W-1:0] TIME_NONE = '1;

   // One stored event
   typedef struct packed {
      logic [TIME_W-1:0] event_time;
      logic [BYTE_W-1:0] second_param;
      logic [BYTE_W-1:0] first_param;
      logic [BYTE_W-1:0] event_code;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/time_ordered_event_queue_unit.sv =====
// Time-ordered event queue: sorted circular store with a sequenced insert shifter.
// Insert: the shift loop reads each later-timed entry and moves it up one slot, then
//   writes the new word behind the first entry that is not later, or at the head when
//   every entry was later; into an empty queue it writes at the head. Take reads the head.
// One word in flight at a time; the next request is taken once the response is delivered.
// Synchronous active-high reset empties the queue; store contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module time_ordered_event_queue_unit
   import toeq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [TIME_W-1:0]   req_event_time,
   input  wire logic [BYTE_W-1:0]   req_event_code,
   input  wire logic [BYTE_W-1:0]   req_first_param,
   input  wire logic [BYTE_W-1:0]   req_second_param,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [TIME_W-1:0]        rsp_head_time,
   output logic [BYTE_W-1:0]        rsp_head_code,
   output logic [BYTE_W-1:0]        rsp_head_first,
   output logic [BYTE_W-1:0]        rsp_head_second,
   output logic [TIME_W-1:0]        rsp_next_time,
   output logic [LIVE_W-1:0]        rsp_live_count
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_INS_RD   = 3'd1;
   localparam logic [2:0] ST_INS_CMP  = 3'd2;
   localparam logic [2:0] ST_INS_PUT  = 3'd3;
   localparam logic [2:0] ST_TAKE_RD  = 3'd4;
   localparam logic [2:0] ST_TAKE_CAP = 3'd5;
   localparam logic [2:0] ST_TAKE_NXT = 3'd6;
   localparam logic [2:0] ST_FIN      = 3'd7;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   // Event store
   entry_type  mem [QUEUE_DEPTH];
   entry_type  rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // Control state
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0] earliest_ff, earliest_in;
   logic [IDX_W-1:0] dst_ff, dst_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   entry_type        item_ff, item_in;

   // Response word
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type           rsp_head_ff, rsp_head_in;
   logic [TIME_W-1:0]   rsp_next_ff, rsp_next_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic             req_take;
   logic [SUM_W-1:0] tail_sum;
   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] src_prev;
   entry_type        req_entry;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_take  = req_valid && !req_stall;

   // Slot one past the last live entry
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
   assign head_next = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
   assign src_prev  = (src_ff == '0) ? IDX_LAST : src_ff - IDX_W'(1);

   assign req_entry.event_time   = req_event_time;
   assign req_entry.event_code   = req_event_code;
   assign req_entry.first_param  = req_first_param;
   assign req_entry.second_param = req_second_param;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      earliest_in   = earliest_ff;
      dst_in        = dst_ff;
      src_in        = src_ff;
      remain_in     = remain_ff;
      item_in       = item_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = dst_ff;
      wr_data       = item_ff;

      // drop the delivered word
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in       = req_entry;
               rsp_status_in = STS_OK;
               rsp_head_in   = '0;
               state_in      = ST_FIN;
               unique case (req_action)
                  ACT_INSERT: begin
                     if (count_ff >= CNT_FULL) begin
                        rsp_status_in = STS_FULL;
                     end else if (count_ff == '0) begin
                        // empty queue: place at head
                        wr_en       = 1'b1;
                        wr_addr     = head_ff;
                        wr_data     = req_entry;
                        count_in    = CNT_ONE;
                        earliest_in = req_event_time;
                     end else begin
                        dst_in    = tail_idx;
                        src_in    = (tail_idx == '0) ? IDX_LAST : tail_idx - IDX_W'(1);
                        remain_in = count_ff;
                        state_in  = ST_INS_RD;
                     end
                  end
                  ACT_TAKE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        state_in = ST_TAKE_RD;
                     end
                  end
                  ACT_CLEAR: begin
                     head_in     = '0;
                     count_in    = '0;
                     earliest_in = TIME_NONE;
                  end
                  ACT_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS_RD: begin
            rd_addr  = src_ff;
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            // move a later entry up one slot, or drop the new word in behind it
            if (rd_data_ff.event_time > item_ff.event_time) begin
               wr_en     = 1'b1;
               wr_addr   = dst_ff;
               wr_data   = rd_data_ff;
               dst_in    = src_ff;
               src_in    = src_prev;
               remain_in = remain_ff - CNT_ONE;
               state_in  = (remain_ff == CNT_ONE) ? ST_INS_PUT : ST_INS_RD;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = dst_ff;
               wr_data  = item_ff;
               count_in = count_ff + CNT_ONE;
               state_in = ST_FIN;
            end
         end
         ST_INS_PUT: begin
            // every entry was later: new word becomes the head
            wr_en       = 1'b1;
            wr_addr     = dst_ff;
            wr_data     = item_ff;
            count_in    = count_ff + CNT_ONE;
            earliest_in = item_ff.event_time;
            state_in    = ST_FIN;
         end
         ST_TAKE_RD: begin
            rd_addr  = head_ff;
            state_in = ST_TAKE_CAP;
         end
         ST_TAKE_CAP: begin
            // capture the head and fetch its successor
            rsp_head_in = rd_data_ff;
            rd_addr     = head_next;
            head_in     = head_next;
            count_in    = count_ff - CNT_ONE;
            if (count_ff == CNT_ONE) begin
               earliest_in = TIME_NONE;
               state_in    = ST_FIN;
            end else begin
               state_in = ST_TAKE_NXT;
            end
         end
         ST_TAKE_NXT: begin
            earliest_in = rd_data_ff.event_time;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_next_in  = earliest_ff;
            rsp_count_in = count_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         earliest_ff  <= TIME_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         earliest_ff  <= earliest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dst_ff        <= dst_in;
      src_ff        <= src_in;
      remain_ff     <= remain_in;
      item_ff       <= item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_time   = rsp_head_ff.event_time;
   assign rsp_head_code   = rsp_head_ff.event_code;
   assign rsp_head_first  = rsp_head_ff.first_param;
   assign rsp_head_second = rsp_head_ff.second_param;
   assign rsp_next_time   = rsp_next_ff;
   assign rsp_live_count  = LIVE_W'(rsp_count_ff);

endmodule

`default_nettype wire
